>>> sv/srsa_pkg.sv
// ----------------------------------------------------------------------------
// srsa_pkg
// Shared constants, codes and helper functions for the sound request slot
// allocator: table geometry, status codes, register indexes and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

package srsa_pkg;

    // Table geometry
    localparam int SLOT_COUNT  = 32;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SOUND_COUNT = 256;

    // Field widths
    localparam int STATUS_W   = 3;
    localparam int SLOT_FLD_W = 5;
    localparam int SOUND_W    = 8;
    localparam int PRIO_W     = 8;
    localparam int FLAGS_W    = 4;
    localparam int PAN_IN_W   = 16;
    localparam int PAN_W      = 15;
    localparam int VREQ_W     = 16;
    localparam int BASE_W     = 15;
    localparam int VOL_W      = 16;
    localparam int MASTER_W   = 7;
    localparam int SCHEMA_W   = 2;
    localparam int CALC_W     = 18;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOUND_DISABLED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_VOLUME  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SFX_SCHEMA     = 2'd2;

    // Register reset values
    localparam logic [MASTER_W-1:0] MASTER_RESET = 7'd100;
    localparam logic [SCHEMA_W-1:0] SCHEMA_RESET = 2'd2;

    // Schema codes
    localparam logic [SCHEMA_W-1:0] SCHEMA_AS1 = 2'd0;
    localparam logic [SCHEMA_W-1:0] SCHEMA_ZS1 = 2'd1;

    // Commands
    localparam logic CMD_PLAY  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_FREE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUIET    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    // Volume and pan constants
    localparam int VOL_FLOOR    = -3000;
    localparam int CLAMP_HI     = 10000;
    localparam int CLAMP_LO     = -10000;
    localparam int MASTER_FULL  = 100;
    localparam int MASTER_SHIFT = 5;      // 32 per master step
    localparam logic [PRIO_W-1:0]  VIP_PRIORITY = 8'd100;
    localparam logic [FLAGS_W-1:0] VIP_FLAG     = 4'h8;

    localparam int VOL_MAX = 32767;
    localparam int VOL_MIN = -32768;

    // Saturate a wide volume to the stored width.
    function automatic logic signed [VOL_W-1:0] sat_vol(input logic signed [CALC_W-1:0] v);
        if (v > CALC_W'(VOL_MAX)) begin
            return VOL_W'(VOL_MAX);
        end else if (v < CALC_W'(VOL_MIN)) begin
            return VOL_W'(VOL_MIN);
        end
        return v[VOL_W-1:0];
    endfunction

    // Clamp a wide volume to +-10000.
    function automatic logic signed [CALC_W-1:0] clamp_vol(input logic signed [CALC_W-1:0] v);
        if (v > CALC_W'(CLAMP_HI)) begin
            return CALC_W'(CLAMP_HI);
        end else if (v < CALC_W'(CLAMP_LO)) begin
            return CALC_W'(CLAMP_LO);
        end
        return v;
    endfunction

    // Clamp the requested pan to +-10000.
    function automatic logic signed [PAN_W-1:0] clamp_pan(input logic signed [PAN_IN_W-1:0] v);
        if (v > PAN_IN_W'(CLAMP_HI)) begin
            return PAN_W'(CLAMP_HI);
        end else if (v < PAN_IN_W'(CLAMP_LO)) begin
            return PAN_W'(CLAMP_LO);
        end
        return v[PAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/sound_request_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// sound_request_slot_allocator_core
// Admits sound play requests into a slot table, computes the stored volume
// and pan, and reports where each request went; also empties single slots.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+-------------------------------
//  request  | in        | i_in_valid / o_in_stall | command, sound fields, clear_slot
//  result   | out       | o_out_valid/i_out_stall | status, slot, volume, pan
//  config   | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//
//  A clear or an invalid request goes from S_CALC straight to S_EMIT, a
//  too-quiet request passes S_CALC and S_DECIDE. A stored request also passes
//  S_SCAN: the scan stops at the first empty slot; a full table is walked
//  over all SLOT_COUNT slots and S_RESOLVE then picks the victim. One table
//  slot is read per cycle, and the sequencer passes through S_IDLE before
//  the next item can be accepted.
//  One item is in work at a time; o_in_stall is high from acceptance until
//  the result has been moved into the output register.
//  A stalled result holds in the output register; the next item may be
//  accepted and worked on meanwhile. Reset empties every slot at once.
//
`default_nettype none

module sound_request_slot_allocator_core (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,

    // configuration write port
    input  wire                                      i_cfg_we,
    input  wire  [srsa_pkg::CFG_INDEX_W-1:0]         i_cfg_index,
    input  wire  [srsa_pkg::CFG_DATA_W-1:0]          i_cfg_data,

    // request channel
    input  wire                                      i_in_valid,
    output logic                                     o_in_stall,
    input  wire                                      i_command,
    input  wire  [srsa_pkg::SOUND_W-1:0]             i_sound_id,
    input  wire                                      i_sound_valid,
    input  wire  signed [srsa_pkg::PAN_IN_W-1:0]     i_pan_request,
    input  wire  signed [srsa_pkg::VREQ_W-1:0]       i_volume_request,
    input  wire  signed [srsa_pkg::BASE_W-1:0]       i_base_volume,
    input  wire  [srsa_pkg::PRIO_W-1:0]              i_sound_priority,
    input  wire  [srsa_pkg::FLAGS_W-1:0]             i_sound_flags,
    input  wire  [srsa_pkg::SLOT_FLD_W-1:0]          i_clear_slot,

    // result channel
    output logic                                     o_out_valid,
    input  wire                                      i_out_stall,
    output logic [srsa_pkg::STATUS_W-1:0]            o_status,
    output logic [srsa_pkg::SLOT_FLD_W-1:0]          o_slot,
    output logic signed [srsa_pkg::VOL_W-1:0]        o_final_volume,
    output logic signed [srsa_pkg::PAN_W-1:0]        o_final_pan
);

    import srsa_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CALC    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_RESOLVE = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // Configuration registers
    logic                       r_disabled;
    logic [MASTER_W-1:0]        r_master;
    logic [SCHEMA_W-1:0]        r_schema;

    // Captured request
    logic                       r_command;
    logic [SOUND_W-1:0]         r_sound_id;
    logic                       r_sound_valid;
    logic signed [PAN_IN_W-1:0] r_pan_req;
    logic signed [VREQ_W-1:0]   r_vreq;
    logic signed [BASE_W-1:0]   r_base;
    logic [PRIO_W-1:0]          r_prio;
    logic [FLAGS_W-1:0]         r_flags;
    logic [SLOT_FLD_W-1:0]      r_cslot;

    // Sequencer and working registers
    logic [2:0]                 r_state, n_state;
    logic signed [CALC_W-1:0]   r_basevol;
    logic signed [CALC_W-1:0]   r_vol;
    logic signed [VOL_W-1:0]    r_svol;
    logic signed [PAN_W-1:0]    r_pan;
    logic [SLOT_W-1:0]          r_idx;
    logic [SLOT_W-1:0]          r_best;
    logic [PRIO_W-1:0]          r_best_prio;
    logic                       r_same;

    // Pending result
    logic [STATUS_W-1:0]        r_res_status;
    logic [SLOT_FLD_W-1:0]      r_res_slot;
    logic signed [VOL_W-1:0]    r_res_vol;
    logic signed [PAN_W-1:0]    r_res_pan;

    // Output register
    logic                       r_out_valid;
    logic [STATUS_W-1:0]        r_out_status;
    logic [SLOT_FLD_W-1:0]      r_out_slot;
    logic signed [VOL_W-1:0]    r_out_vol;
    logic signed [PAN_W-1:0]    r_out_pan;

    // Slot table: used bits reset at once, the rest is written before it is read
    logic [SLOT_COUNT-1:0]      r_used;
    logic [SOUND_W-1:0]         r_tab_sound [SLOT_COUNT];
    logic [PRIO_W-1:0]          r_tab_prio  [SLOT_COUNT];

    // Combinational terms
    logic                       w_in_accept;
    logic                       w_out_free;
    logic                       w_invalid;
    logic                       w_clear_hit;
    logic signed [CALC_W-1:0]   w_master_off;
    logic signed [CALC_W-1:0]   w_basevol;
    logic signed [CALC_W-1:0]   w_vol;
    logic                       w_vip;
    logic signed [CALC_W-1:0]   w_sel;
    logic signed [CALC_W-1:0]   w_lim;
    logic                       w_scan_free;
    logic                       w_dup;
    logic                       w_tab_we;
    logic [SLOT_W-1:0]          w_tab_addr;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_final_volume = r_out_vol;
    assign o_final_pan    = r_out_pan;

    // Volume arithmetic: master offset is (master - 100) * 32
    always_comb begin
        w_master_off = (CALC_W'(signed'({1'b0, r_master})) - CALC_W'(MASTER_FULL))
                       <<< MASTER_SHIFT;
        w_basevol    = CALC_W'(r_base) + w_master_off;
        w_vol        = CALC_W'(r_vreq) + w_basevol;
        // vip: priority 100 under AS1, flag bit otherwise
        w_vip        = (r_schema == SCHEMA_AS1) ? (r_prio == VIP_PRIORITY)
                                                : ((r_flags & VIP_FLAG) != '0);
        w_sel        = w_vip ? r_basevol : r_vol;
        w_lim        = (r_schema == SCHEMA_ZS1) ? clamp_vol(w_sel) : w_sel;
    end

    assign w_invalid   = r_disabled || !r_sound_valid || (32'(r_sound_id) >= SOUND_COUNT);
    assign w_clear_hit = (32'(r_cslot) < SLOT_COUNT);
    assign w_scan_free = !r_used[r_idx];
    // Lowest priority landed on slot 0 while a later slot holds the same sound
    assign w_dup       = (r_best == '0) && r_same;

    // Table write port: first free slot during the scan, or the victim slot
    always_comb begin
        w_tab_we   = 1'b0;
        w_tab_addr = r_idx;
        if (r_state == S_SCAN && w_scan_free) begin
            w_tab_we = 1'b1;
        end else if (r_state == S_RESOLVE && !w_dup) begin
            w_tab_we   = 1'b1;
            w_tab_addr = r_best;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) n_state = S_CALC;
            end
            S_CALC: begin
                if (r_command == CMD_CLEAR || w_invalid) n_state = S_EMIT;
                else                                     n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_vol < CALC_W'(VOL_FLOOR)) n_state = S_EMIT;
                else                            n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_scan_free)             n_state = S_EMIT;
                else if (r_idx == LAST_SLOT) n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration, used bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_disabled  <= 1'b0;
            r_master    <= MASTER_RESET;
            r_schema    <= SCHEMA_RESET;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SOUND_DISABLED: r_disabled <= i_cfg_data[0];
                    CFG_MASTER_VOLUME:  r_master   <= i_cfg_data[MASTER_W-1:0];
                    CFG_SFX_SCHEMA:     r_schema   <= i_cfg_data[SCHEMA_W-1:0];
                    default: ;
                endcase
            end

            // clear command empties its slot, even while sound is disabled
            if (r_state == S_CALC && r_command == CMD_CLEAR && w_clear_hit) begin
                r_used[SLOT_W'(r_cslot)] <= 1'b0;
            end
            if (w_tab_we) begin
                r_used[w_tab_addr] <= 1'b1;
            end

            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_command     <= i_command;
            r_sound_id    <= i_sound_id;
            r_sound_valid <= i_sound_valid;
            r_pan_req     <= i_pan_request;
            r_vreq        <= i_volume_request;
            r_base        <= i_base_volume;
            r_prio        <= i_sound_priority;
            r_flags       <= i_sound_flags;
            r_cslot       <= i_clear_slot;
        end

        unique case (r_state)
            S_CALC: begin
                r_basevol <= w_basevol;
                r_vol     <= w_vol;
                if (r_command == CMD_CLEAR) begin
                    r_res_status <= ST_CLEARED;
                    r_res_slot   <= r_cslot;
                end else begin
                    r_res_status <= ST_INVALID;
                    r_res_slot   <= '0;
                end
                r_res_vol <= '0;
                r_res_pan <= '0;
            end
            S_DECIDE: begin
                // too quiet: report the raw volume, store nothing
                r_res_status <= ST_QUIET;
                r_res_slot   <= '0;
                r_res_vol    <= sat_vol(r_vol);
                r_res_pan    <= clamp_pan(r_pan_req);
                r_svol       <= sat_vol(w_lim);
                r_pan        <= clamp_pan(r_pan_req);
                r_idx        <= '0;
                r_best       <= '0;
                r_best_prio  <= '0;
                r_same       <= 1'b0;
            end
            S_SCAN: begin
                if (w_scan_free) begin
                    r_res_status <= ST_FREE;
                    r_res_slot   <= SLOT_FLD_W'(r_idx);
                    r_res_vol    <= r_svol;
                    r_res_pan    <= r_pan;
                end else begin
                    // track lowest priority, first index on ties
                    if (r_idx == '0 || r_tab_prio[r_idx] < r_best_prio) begin
                        r_best      <= r_idx;
                        r_best_prio <= r_tab_prio[r_idx];
                    end
                    if (r_idx != '0 && r_tab_sound[r_idx] == r_sound_id) begin
                        r_same <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_RESOLVE: begin
                r_res_status <= w_dup ? ST_DUP : ST_REPLACED;
                r_res_slot   <= w_dup ? '0 : SLOT_FLD_W'(r_best);
                r_res_vol    <= r_svol;
                r_res_pan    <= r_pan;
            end
            default: ;
        endcase

        // load the output register only when it is free; hold while stalled
        if (r_state == S_EMIT && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_vol    <= r_res_vol;
            r_out_pan    <= r_res_pan;
        end

        if (w_tab_we) begin
            r_tab_sound[w_tab_addr] <= r_sound_id;
            r_tab_prio[w_tab_addr]  <= r_prio;
        end
    end

endmodule

`default_nettype wire

>>> dv/srsa_allocation_check.sv
// ----------------------------------------------------------------------------
// srsa_allocation_check
// Watches the request, result and register ports of the slot allocator, keeps
// its own slot table and register copies, works out the outcome of every
// accepted request and compares each accepted result, field by field, with
// the oldest outcome still owed.
// ----------------------------------------------------------------------------
module srsa_allocation_check (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    input  logic                                    i_cfg_we,
    input  logic [srsa_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [srsa_pkg::CFG_DATA_W-1:0]         i_cfg_data,

    input  logic                                    i_in_valid,
    input  logic                                    i_in_stall,
    input  logic                                    i_command,
    input  logic [srsa_pkg::SOUND_W-1:0]            i_sound_id,
    input  logic                                    i_sound_valid,
    input  logic signed [srsa_pkg::PAN_IN_W-1:0]    i_pan_request,
    input  logic signed [srsa_pkg::VREQ_W-1:0]      i_volume_request,
    input  logic signed [srsa_pkg::BASE_W-1:0]      i_base_volume,
    input  logic [srsa_pkg::PRIO_W-1:0]             i_sound_priority,
    input  logic [srsa_pkg::FLAGS_W-1:0]            i_sound_flags,
    input  logic [srsa_pkg::SLOT_FLD_W-1:0]         i_clear_slot,

    input  logic                                    i_out_valid,
    input  logic                                    i_out_stall,
    input  logic [srsa_pkg::STATUS_W-1:0]           i_status,
    input  logic [srsa_pkg::SLOT_FLD_W-1:0]         i_slot,
    input  logic signed [srsa_pkg::VOL_W-1:0]       i_final_volume,
    input  logic signed [srsa_pkg::PAN_W-1:0]       i_final_pan,

    output int                                      o_fail_count,
    output int                                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import srsa_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic [SLOT_FLD_W-1:0]        slot;
        logic signed [VOL_W-1:0]      volume;
        logic signed [PAN_W-1:0]      pan;
    } t_outcome;

    // Register copies
    logic                 muted;
    logic [MASTER_W-1:0]  master;
    logic [SCHEMA_W-1:0]  schema;

    // Slot table: only occupancy, sound and priority steer later decisions
    logic                 table_used  [SLOT_COUNT];
    logic [SOUND_W-1:0]   table_sound [SLOT_COUNT];
    logic [PRIO_W-1:0]    table_prio  [SLOT_COUNT];

    t_outcome owed_outcomes[$];
    int       mismatch_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int limit(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Work out the outcome of one request and update the table.
    function automatic t_outcome allocate_request(
        input logic                       cmd,
        input logic [SOUND_W-1:0]         id,
        input logic                       loaded,
        input logic signed [PAN_IN_W-1:0] pan_in,
        input logic signed [VREQ_W-1:0]   vreq,
        input logic signed [BASE_W-1:0]   base,
        input logic [PRIO_W-1:0]          prio,
        input logic [FLAGS_W-1:0]         flags,
        input logic [SLOT_FLD_W-1:0]      cslot
    );
        t_outcome    o;
        int          gain;
        int          level;
        logic        vip;
        logic        dup;
        int unsigned victim;

        o = '0;
        if (cmd == CMD_CLEAR) begin
            if (cslot < SLOT_COUNT) begin
                table_used[cslot] = 1'b0;
            end
            o.status = ST_CLEARED;
            o.slot   = cslot;
            return o;
        end
        if (muted || !loaded || id >= SOUND_COUNT) begin
            o.status = ST_INVALID;
            return o;
        end

        gain  = int'(base) + (1 << MASTER_SHIFT) * (int'(master) - MASTER_FULL);
        level = int'(vreq) + gain;
        o.pan = PAN_W'(limit(int'(pan_in), CLAMP_LO, CLAMP_HI));
        if (level < VOL_FLOOR) begin
            o.status = ST_QUIET;
            o.volume = VOL_W'(limit(level, VOL_MIN, VOL_MAX));
            return o;
        end

        vip = (schema == SCHEMA_AS1) ? (prio == VIP_PRIORITY) : ((flags & VIP_FLAG) != '0);
        if (vip) begin
            level = gain;
        end
        if (schema == SCHEMA_ZS1) begin
            level = limit(level, CLAMP_LO, CLAMP_HI);
        end
        o.volume = VOL_W'(limit(level, VOL_MIN, VOL_MAX));

        // First empty slot, else the lowest priority (lowest index on ties)
        victim = SLOT_COUNT;
        for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
            if (!table_used[k] && victim == SLOT_COUNT) begin
                victim = k;
            end
        end
        if (victim < SLOT_COUNT) begin
            o.status = ST_FREE;
        end else begin
            victim = 0;
            dup    = 1'b0;
            for (int unsigned k = 1; k < SLOT_COUNT; k++) begin
                if (table_sound[k] == id) begin
                    dup = 1'b1;
                end
                if (table_prio[k] < table_prio[victim]) begin
                    victim = k;
                end
            end
            if (victim == 0 && dup) begin
                o.status = ST_DUP;
                return o;
            end
            o.status = ST_REPLACED;
        end

        table_used[victim]  = 1'b1;
        table_sound[victim] = id;
        table_prio[victim]  = prio;
        o.slot = SLOT_FLD_W'(victim);
        return o;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome seen;
        t_outcome want;

        if (!i_rst_n) begin
            muted  = 1'b0;
            master = MASTER_RESET;
            schema = SCHEMA_RESET;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                table_used[k]  = 1'b0;
                table_sound[k] = '0;
                table_prio[k]  = '0;
            end
            owed_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SOUND_DISABLED: muted  = i_cfg_data[0];
                    CFG_MASTER_VOLUME:  master = i_cfg_data[MASTER_W-1:0];
                    CFG_SFX_SCHEMA:     schema = i_cfg_data[SCHEMA_W-1:0];
                    default: ;
                endcase
            end

            // Compare before adding: a result is always older than this edge's request
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_status, i_slot, i_final_volume, i_final_pan};
                if (owed_outcomes.size() == 0) begin
                    $error("result with no request waiting: status %0d slot %0d",
                           seen.status, seen.slot);
                    mismatch_count++;
                end else begin
                    want = owed_outcomes.pop_front();
                    if (seen.status != want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, seen.status);
                        mismatch_count++;
                    end
                    if (seen.slot != want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, seen.slot);
                        mismatch_count++;
                    end
                    if (seen.volume != want.volume) begin
                        $error("final_volume: expected %0d, actual %0d",
                               want.volume, seen.volume);
                        mismatch_count++;
                    end
                    if (seen.pan != want.pan) begin
                        $error("final_pan: expected %0d, actual %0d", want.pan, seen.pan);
                        mismatch_count++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                owed_outcomes.push_back(allocate_request(
                    i_command, i_sound_id, i_sound_valid, i_pan_request,
                    i_volume_request, i_base_volume, i_sound_priority,
                    i_sound_flags, i_clear_slot));
            end
        end

        o_pending    <= owed_outcomes.size();
        o_fail_count <= mismatch_count;
    end

endmodule

>>> dv/sound_request_slot_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// sound_request_slot_allocator_core_tb
// Drives play and clear requests into the slot allocator under several
// register settings, with random gaps on the request side and random stalls
// on the result side; the allocation check beside the block does the
// predicting and comparing, and this module gives the verdict.
// ----------------------------------------------------------------------------
module sound_request_slot_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srsa_pkg::*;

    // Schema codes the package leaves unnamed
    localparam logic [SCHEMA_W-1:0] SCHEMA_OTHER = 2'd2;
    localparam logic [SCHEMA_W-1:0] SCHEMA_SPARE = 2'd3;

    localparam int HOLD_CYCLES    = 300;   // long result hold-off
    localparam int SETTLE_CYCLES  = 40;    // a little over one full slot scan
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving either way
    localparam int PHASE_ITEMS    = 125;

    typedef struct packed {
        logic                         command;
        logic [SOUND_W-1:0]           sound_id;
        logic                         sound_valid;
        logic signed [PAN_IN_W-1:0]   pan_request;
        logic signed [VREQ_W-1:0]     volume_request;
        logic signed [BASE_W-1:0]     base_volume;
        logic [PRIO_W-1:0]            sound_priority;
        logic [FLAGS_W-1:0]           sound_flags;
        logic [SLOT_FLD_W-1:0]        clear_slot;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                         i_cfg_we;
    logic [CFG_INDEX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;

    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_command;
    logic [SOUND_W-1:0]           i_sound_id;
    logic                         i_sound_valid;
    logic signed [PAN_IN_W-1:0]   i_pan_request;
    logic signed [VREQ_W-1:0]     i_volume_request;
    logic signed [BASE_W-1:0]     i_base_volume;
    logic [PRIO_W-1:0]            i_sound_priority;
    logic [FLAGS_W-1:0]           i_sound_flags;
    logic [SLOT_FLD_W-1:0]        i_clear_slot;

    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [STATUS_W-1:0]          o_status;
    logic [SLOT_FLD_W-1:0]        o_slot;
    logic signed [VOL_W-1:0]      o_final_volume;
    logic signed [PAN_W-1:0]      o_final_pan;

    int fail_count;
    int pending;

    // Knobs the stimulus turns per phase; push_request and the result sink read them
    bit no_send_gaps  = 1'b0;
    bit no_out_stalls = 1'b0;
    bit hold_results  = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sound_request_slot_allocator_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_sound_id       (i_sound_id),
        .i_sound_valid    (i_sound_valid),
        .i_pan_request    (i_pan_request),
        .i_volume_request (i_volume_request),
        .i_base_volume    (i_base_volume),
        .i_sound_priority (i_sound_priority),
        .i_sound_flags    (i_sound_flags),
        .i_clear_slot     (i_clear_slot),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_final_volume   (o_final_volume),
        .o_final_pan      (o_final_pan)
    );

    srsa_allocation_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_sound_id       (i_sound_id),
        .i_sound_valid    (i_sound_valid),
        .i_pan_request    (i_pan_request),
        .i_volume_request (i_volume_request),
        .i_base_volume    (i_base_volume),
        .i_sound_priority (i_sound_priority),
        .i_sound_flags    (i_sound_flags),
        .i_clear_slot     (i_clear_slot),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_slot           (o_slot),
        .i_final_volume   (o_final_volume),
        .i_final_pan      (o_final_pan),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Build a loaded play request.
    function automatic t_request make_play(input int id, input int prio, input int flags,
                                           input int pan, input int vreq, input int base);
        t_request r;
        r                = '0;
        r.command        = CMD_PLAY;
        r.sound_valid    = 1'b1;
        r.sound_id       = SOUND_W'(id);
        r.sound_priority = PRIO_W'(prio);
        r.sound_flags    = FLAGS_W'(flags);
        r.pan_request    = PAN_IN_W'(pan);
        r.volume_request = VREQ_W'(vreq);
        r.base_volume    = BASE_W'(base);
        return r;
    endfunction

    function automatic t_request make_clear(input int slot);
        t_request r;
        r            = '0;
        r.command    = CMD_CLEAR;
        r.clear_slot = SLOT_FLD_W'(slot);
        return r;
    endfunction

    // Mostly loud plays from a small pool of sounds and priorities so the
    // table fills, replaces and hits duplicates; the rest clears, unloaded
    // sounds and raw noise.
    function automatic t_request random_request(input int unsigned clear_pct);
        t_request    r;
        int unsigned pick;

        pick = $urandom_range(0, 99);
        r = make_play(($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 255),
                      0, $urandom_range(0, 15), $urandom, 0, 0);
        r.volume_request = ($urandom_range(0, 99) < 80)
                         ? VREQ_W'(int'($urandom_range(0, 6000)) - 3000) : VREQ_W'($urandom);
        r.base_volume    = ($urandom_range(0, 99) < 70)
                         ? BASE_W'(int'($urandom_range(0, 13000)) - 3000)
                         : BASE_W'(int'($urandom_range(0, 20000)) - 10000);
        case ($urandom_range(0, 19)) inside
            [0:2]:   r.sound_priority = VIP_PRIORITY;
            [3:9]:   r.sound_priority = PRIO_W'($urandom);
            default: r.sound_priority = PRIO_W'($urandom_range(0, 3));
        endcase
        r.clear_slot = SLOT_FLD_W'($urandom_range(0, 31));

        if (pick < clear_pct) begin
            r.command = CMD_CLEAR;
        end else if (pick < clear_pct + 8) begin
            r.sound_valid = 1'b0;
        end else if (pick < clear_pct + 12) begin
            r.command        = logic'($urandom_range(0, 1));
            r.sound_valid    = logic'($urandom_range(0, 1));
            r.volume_request = VREQ_W'($urandom);
        end
        return r;
    endfunction

    // Offer one item, hold it until accepted, then maybe leave a gap.
    task automatic push_request(input t_request r);
        int unsigned pick;
        int unsigned gap;

        i_in_valid       <= 1'b1;
        i_command        <= r.command;
        i_sound_id       <= r.sound_id;
        i_sound_valid    <= r.sound_valid;
        i_pan_request    <= r.pan_request;
        i_volume_request <= r.volume_request;
        i_base_volume    <= r.base_volume;
        i_sound_priority <= r.sound_priority;
        i_sound_flags    <= r.sound_flags;
        i_clear_slot     <= r.clear_slot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);

        gap = 0;
        if (!no_send_gaps) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92) begin
                gap = $urandom_range(10, 40);
            end else if (pick >= 55) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write all three registers, one per cycle; call only while idle.
    task automatic configure(input logic muted, input logic [MASTER_W-1:0] master,
                             input logic [SCHEMA_W-1:0] schema);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SOUND_DISABLED;
        i_cfg_data  <= CFG_DATA_W'(muted);
        @(posedge i_clk);
        i_cfg_index <= CFG_MASTER_VOLUME;
        i_cfg_data  <= CFG_DATA_W'(master);
        @(posedge i_clk);
        i_cfg_index <= CFG_SFX_SCHEMA;
        i_cfg_data  <= CFG_DATA_W'(schema);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls, stall-free stretches and one long hold-off.
    initial begin : result_sink
        int unsigned pick;

        forever begin
            if (hold_results) begin
                // Hold every result so the block fills up and stalls requests
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else if (no_out_stalls) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end else if (pick < 92) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // End the run when no item has moved on either channel for too long.
    initial begin : watchdog
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        t_request    r;
        int unsigned clear_pct;
        int unsigned count;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_SOUND_DISABLED;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_command        <= CMD_PLAY;
        i_sound_id       <= '0;
        i_sound_valid    <= 1'b0;
        i_pan_request    <= '0;
        i_volume_request <= '0;
        i_base_volume    <= '0;
        i_sound_priority <= '0;
        i_sound_flags    <= '0;
        i_clear_slot     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: enabled, full master, other schema
        push_request(make_play(0, 0, 0, 0, 0, 0));
        // vip by flag bit 3: keep the base volume only; pan clamps high
        push_request(make_play(255, 255, 15, 32767, 32767, 10000));
        // volume saturates high, pan clamps low
        push_request(make_play(7, 1, 0, -32768, 32767, 10000));
        // lowest request and base: too quiet, saturated low
        push_request(make_play(9, 2, 0, -32768, -32768, -10000));
        // right on the floor is kept, one below is dropped
        push_request(make_play(10, 3, 0, 5, -3000, 0));
        push_request(make_play(11, 3, 0, -5, -3001, 0));
        // unloaded sound
        r = make_play(12, 4, 0, 0, 0, 0);
        r.sound_valid = 1'b0;
        push_request(r);
        // clear an empty slot and an occupied one
        push_request(make_clear(31));
        push_request(make_clear(0));

        // AS1 marks vip by priority 100; master at zero
        wait_idle();
        configure(1'b0, 7'd0, SCHEMA_AS1);
        push_request(make_play(20, VIP_PRIORITY, 0, 100, 5000, 10000));
        push_request(make_play(21, 99, 8, -100, 5000, 10000));

        // ZS1 clamps a stored volume; master above range raises it
        wait_idle();
        configure(1'b0, 7'd127, SCHEMA_ZS1);
        push_request(make_play(22, 50, 0, 0, 32767, 10000));
        push_request(make_play(23, 50, 0, 0, -2000, -10000));

        // Disabled: plays are refused, clears still work; spare schema code
        wait_idle();
        configure(1'b1, MASTER_RESET, SCHEMA_SPARE);
        push_request(make_play(24, 50, 0, 0, 0, 0));
        push_request(make_clear(1));

        // Spare schema code behaves as the other schema
        wait_idle();
        configure(1'b0, MASTER_RESET, SCHEMA_SPARE);
        push_request(make_play(25, 60, 8, 0, 1000, 2000));

        // Random phases, each under its own settings
        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            case (phase)
                0:       configure(1'b0, 7'd0, SCHEMA_AS1);
                1:       configure(1'b0, MASTER_RESET, SCHEMA_ZS1);
                2:       configure(1'b0, 7'd127, SCHEMA_OTHER);
                3:       configure(1'b1, MASTER_W'($urandom), SCHEMA_W'($urandom));
                default: configure(1'b0, MASTER_W'($urandom_range(40, 127)), SCHEMA_W'($urandom));
            endcase
            no_send_gaps  = (phase == 4);
            no_out_stalls = (phase == 4 || phase == 5);
            hold_results  = (phase == 2);
            clear_pct     = (phase == 7) ? 3 : ((phase % 2 == 0) ? 10 : 35);
            count         = (phase == 3) ? 20 : PHASE_ITEMS;
            repeat (count) push_request(random_request(clear_pct));
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/srsa_pkg.sv
sv/sound_request_slot_allocator_core.sv
dv/srsa_allocation_check.sv
dv/sound_request_slot_allocator_core_tb.sv
